/* design/wsd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; the parser, the result register and the top import this package.
package wsd_pkg;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_CLOSE     = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [9:0] CLOSE_NORMAL   = 10'd1000;
  localparam logic [9:0] CLOSE_PROTOCOL = 10'd1002;
  localparam logic [9:0] CLOSE_TOO_BIG  = 10'd1009;

  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam int         CTRL_MAX_LEN = 125;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] msg_type;
    logic       last_of_message;
    logic [9:0] close_code;
  } res_t;

endpackage

/* design/wsd_byte_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel that carries one received byte per item.
// No dependencies.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* design/wsd_res_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel that carries one deframer result per item.
// No dependencies.
interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] msg_type;
  logic       last_of_message;
  logic [9:0] close_code;

  modport source (output valid, output kind, output out_byte, output msg_type,
                  output last_of_message, output close_code, input ready);
  modport sink (input valid, input kind, input out_byte, input msg_type,
                input last_of_message, input close_code, output ready);
endinterface

/* design/wsd_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the deframer: captures one received byte per item.
// Depends on wsd_byte_if.
module wsd_in_stage (
  input  logic         clk,
  input  logic         rst,
  wsd_byte_if.sink     rx,
  input  logic         advance,
  output logic         held_valid,
  output logic [7:0]   held_byte
);

  assign rx.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      held_byte <= rx.in_byte;
    end
  end

endmodule

/* design/wsd_parser.sv */
`timescale 1ns / 1ps
// Frame parser: header walk, length and mask capture, unmasking, fragment
// tracking and close handling, one byte per step. Depends on wsd_pkg.
module wsd_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data,
  output logic          res_valid,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_LEN16, PH_LEN64, PH_MASK, PH_PAYLOAD
  } phase_t;

  phase_t                 parse_phase, parse_phase_next;
  logic [2:0]             header_byte_count, header_byte_count_next;
  logic                   frame_fin, frame_fin_next;
  logic [2:0]             frame_rsvd, frame_rsvd_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   frame_masked, frame_masked_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [LENGTH_BITS-1:0] payload_remaining, payload_remaining_next;
  logic [1:0]             payload_index, payload_index_next;
  logic                   length_high_nonzero, length_high_nonzero_next;
  logic [3:0]             message_in_progress, message_in_progress_next;
  logic [15:0]            close_code_acc, close_code_acc_next;
  logic                   connection_closed, connection_closed_next;

  logic [LENGTH_BITS+7:0] len_shift;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [7:0]             key_byte;
  logic [7:0]             plain_byte;
  logic [15:0]            status_code;
  logic                   after_len;
  logic                   hdr_end;
  logic                   do_close;
  logic [9:0]             close_sel;
  logic                   bad;
  logic [3:0]             msg_op;

  assign len_shift   = {payload_remaining, data};
  assign rem_dec     = payload_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign key_byte    = frame_masked ? mask_key[8*(3-payload_index) +: 8] : 8'h00;
  assign plain_byte  = data ^ key_byte;
  assign status_code = close_code_acc | {8'h00, plain_byte};

  always_comb begin
    parse_phase_next         = parse_phase;
    header_byte_count_next   = header_byte_count;
    frame_fin_next           = frame_fin;
    frame_rsvd_next          = frame_rsvd;
    frame_opcode_next        = frame_opcode;
    frame_masked_next        = frame_masked;
    mask_key_next            = mask_key;
    payload_remaining_next   = payload_remaining;
    payload_index_next       = payload_index;
    length_high_nonzero_next = length_high_nonzero;
    message_in_progress_next = message_in_progress;
    close_code_acc_next      = close_code_acc;
    connection_closed_next   = connection_closed;
    res_valid                = 1'b0;
    res                      = '0;
    after_len                = 1'b0;
    hdr_end                  = 1'b0;
    do_close                 = 1'b0;
    close_sel                = CLOSE_PROTOCOL;
    bad                      = 1'b0;
    msg_op                   = message_in_progress;

    if (step && !connection_closed) begin
      case (parse_phase)
        PH_HDR0: begin
          frame_fin_next    = data[7];
          frame_rsvd_next   = data[6:4];
          frame_opcode_next = data[3:0];
          parse_phase_next  = PH_HDR1;
        end
        PH_HDR1: begin
          frame_masked_next        = data[7];
          length_high_nonzero_next = 1'b0;
          header_byte_count_next   = 3'd0;
          payload_remaining_next   = '0;
          mask_key_next            = '0;
          if (data[6:0] == LEN7_EXT16) begin
            parse_phase_next = PH_LEN16;
          end else if (data[6:0] == LEN7_EXT64) begin
            parse_phase_next = PH_LEN64;
          end else begin
            payload_remaining_next = LENGTH_BITS'(data[6:0]);
            after_len              = 1'b1;
          end
        end
        PH_LEN16: begin
          payload_remaining_next   = len_shift[LENGTH_BITS-1:0];
          length_high_nonzero_next = length_high_nonzero
                                     | (|len_shift[LENGTH_BITS+7:LENGTH_BITS]);
          if (header_byte_count >= 3'd1) begin
            after_len = 1'b1;
          end else begin
            header_byte_count_next = header_byte_count + 3'd1;
          end
        end
        PH_LEN64: begin
          if (header_byte_count < 3'd4) begin
            if (data != 8'h00) begin
              length_high_nonzero_next = 1'b1;
            end
          end else begin
            payload_remaining_next   = len_shift[LENGTH_BITS-1:0];
            length_high_nonzero_next = length_high_nonzero
                                       | (|len_shift[LENGTH_BITS+7:LENGTH_BITS]);
          end
          if (header_byte_count >= 3'd7) begin
            after_len = 1'b1;
          end else begin
            header_byte_count_next = header_byte_count + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], data};
          if (header_byte_count >= 3'd3) begin
            header_byte_count_next = 3'd0;
            hdr_end                = 1'b1;
          end else begin
            header_byte_count_next = header_byte_count + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          payload_index_next     = payload_index + 2'd1;
          payload_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            parse_phase_next = PH_HDR0;
          end
          case (frame_opcode)
            OP_CLOSE: begin
              if (payload_index == 2'd0) begin
                close_code_acc_next = {plain_byte, 8'h00};
              end else begin
                close_code_acc_next = status_code;
                do_close            = 1'b1;
                if (status_code inside {[16'd1000:16'd1003], [16'd1007:16'd1011],
                                        [16'd3000:16'd4999]}) begin
                  close_sel = CLOSE_NORMAL;
                end else begin
                  close_sel = CLOSE_PROTOCOL;
                end
              end
            end
            OP_PONG: begin
              res_valid = 1'b0;
            end
            OP_PING: begin
              res_valid           = 1'b1;
              res.kind            = KIND_DATA;
              res.out_byte        = plain_byte;
              res.msg_type        = OP_PONG;
              res.last_of_message = (rem_dec == '0);
            end
            default: begin
              res_valid           = 1'b1;
              res.kind            = KIND_DATA;
              res.out_byte        = plain_byte;
              res.msg_type        = message_in_progress;
              res.last_of_message = (rem_dec == '0) && frame_fin;
              if ((rem_dec == '0) && frame_fin) begin
                message_in_progress_next = 4'd0;
              end
            end
          endcase
        end
        default: begin
          parse_phase_next = PH_HDR0;
        end
      endcase

      if (after_len) begin
        if (length_high_nonzero_next) begin
          do_close  = 1'b1;
          close_sel = CLOSE_TOO_BIG;
        end else begin
          header_byte_count_next = 3'd0;
          if (frame_masked_next) begin
            parse_phase_next = PH_MASK;
          end else begin
            hdr_end = 1'b1;
          end
        end
      end

      if (hdr_end) begin
        payload_index_next = 2'd0;
        bad = (frame_rsvd != 3'd0)
           || (frame_opcode >= OP_CLOSE
               && (payload_remaining_next > LENGTH_BITS'(CTRL_MAX_LEN) || !frame_fin))
           || (frame_opcode == OP_CLOSE
               && payload_remaining_next == LENGTH_BITS'(1))
           || (frame_opcode == OP_CONT && message_in_progress == 4'd0)
           || ((frame_opcode == OP_TEXT || frame_opcode == OP_BINARY)
               && message_in_progress != 4'd0)
           || (frame_opcode inside {[4'd3:4'd7], [4'd11:4'd15]});
        if (frame_opcode == OP_TEXT || frame_opcode == OP_BINARY) begin
          msg_op = frame_opcode;
        end
        if (bad) begin
          do_close  = 1'b1;
          close_sel = CLOSE_PROTOCOL;
        end else if (payload_remaining_next != '0) begin
          parse_phase_next         = PH_PAYLOAD;
          message_in_progress_next = msg_op;
        end else begin
          parse_phase_next = PH_HDR0;
          case (frame_opcode)
            OP_CLOSE: begin
              do_close  = 1'b1;
              close_sel = CLOSE_NORMAL;
            end
            OP_PONG: begin
              res_valid = 1'b0;
            end
            OP_PING: begin
              res_valid           = 1'b1;
              res.kind            = KIND_EMPTY_END;
              res.msg_type        = OP_PONG;
              res.last_of_message = 1'b1;
            end
            default: begin
              if (frame_fin) begin
                res_valid                = 1'b1;
                res.kind                 = KIND_EMPTY_END;
                res.msg_type             = msg_op;
                res.last_of_message      = 1'b1;
                message_in_progress_next = 4'd0;
              end else begin
                message_in_progress_next = msg_op;
              end
            end
          endcase
        end
      end

      if (do_close) begin
        connection_closed_next = 1'b1;
        parse_phase_next       = PH_HDR0;
        res_valid              = 1'b1;
        res                    = '0;
        res.kind               = KIND_CLOSE;
        res.close_code         = close_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_HDR0;
      header_byte_count   <= 3'd0;
      frame_fin           <= 1'b0;
      frame_rsvd          <= 3'd0;
      frame_opcode        <= 4'd0;
      frame_masked        <= 1'b0;
      mask_key            <= '0;
      payload_remaining   <= '0;
      payload_index       <= 2'd0;
      length_high_nonzero <= 1'b0;
      message_in_progress <= 4'd0;
      close_code_acc      <= 16'd0;
      connection_closed   <= 1'b0;
    end else begin
      parse_phase         <= parse_phase_next;
      header_byte_count   <= header_byte_count_next;
      frame_fin           <= frame_fin_next;
      frame_rsvd          <= frame_rsvd_next;
      frame_opcode        <= frame_opcode_next;
      frame_masked        <= frame_masked_next;
      mask_key            <= mask_key_next;
      payload_remaining   <= payload_remaining_next;
      payload_index       <= payload_index_next;
      length_high_nonzero <= length_high_nonzero_next;
      message_in_progress <= message_in_progress_next;
      close_code_acc      <= close_code_acc_next;
      connection_closed   <= connection_closed_next;
    end
  end

endmodule

/* design/wsd_out_stage.sv */
`timescale 1ns / 1ps
// Result register of the deframer: holds one result until the sink takes it.
// Depends on wsd_pkg and wsd_res_if.
module wsd_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  wsd_pkg::res_t res,
  output logic          advance,
  wsd_res_if.source     tx
);
  import wsd_pkg::*;

  res_t held;

  assign advance = !tx.valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (advance) begin
      tx.valid <= load;
    end
    if (advance && load) begin
      held <= res;
    end
  end

  assign tx.kind            = held.kind;
  assign tx.out_byte        = held.out_byte;
  assign tx.msg_type        = held.msg_type;
  assign tx.last_of_message = held.last_of_message;
  assign tx.close_code      = held.close_code;

endmodule

/* design/websocket_frame_deframer_top.sv */
`timescale 1ns / 1ps
// WebSocket receive-side deframer: takes one raw byte per item on rx and
// gives unmasked payload bytes, message ends and close requests on tx. The
// block accepts a byte every clock cycle while the result register is free or
// being drained; each byte is held in the input register, passes the parser,
// and its result, if any, is registered on tx as the parser takes the byte
// from the input register. The parser, which updates its state once per
// byte, sets this rate. After a close request all bytes are taken and
// dropped until reset. LENGTH_BITS (16 to 32) is the widest payload length
// supported; longer frames give close code 1009.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  wsd_byte_if.sink  rx,
  wsd_res_if.source tx
);
  import wsd_pkg::*;

  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       res_valid;
  res_t       res;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (held_valid && advance),
    .data      (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (res_valid),
    .res     (res),
    .advance (advance),
    .tx      (tx)
  );

endmodule
